[rtl/core/pur_pkg.sv]
// shared types and constants for the picture unit register port
`timescale 1ns / 1ps
package pur_pkg;

    localparam int unsigned PATTERN_BYTES   = 8192;
    localparam int unsigned SPRITE_BYTES    = 256;
    localparam int unsigned PALETTE_ENTRIES = 32;

    localparam logic [1:0] KIND_READ   = 2'd0;
    localparam logic [1:0] KIND_WRITE  = 2'd1;
    localparam logic [1:0] KIND_STATUS = 2'd2;

    localparam logic [2:0] REG_CTRL   = 3'd0;
    localparam logic [2:0] REG_MASK   = 3'd1;
    localparam logic [2:0] REG_STATUS = 3'd2;
    localparam logic [2:0] REG_SPTR   = 3'd3;
    localparam logic [2:0] REG_SDATA  = 3'd4;
    localparam logic [2:0] REG_SCROLL = 3'd5;
    localparam logic [2:0] REG_ADDR   = 3'd6;
    localparam logic [2:0] REG_DATA   = 3'd7;

    localparam logic [1:0] MIRROR_HORZ = 2'd0;
    localparam logic [1:0] MIRROR_VERT = 2'd1;

    typedef enum logic [3:0] {
        OP_NOP,
        OP_STATUS_RD,
        OP_SPRITE_RD,
        OP_DATA_RD,
        OP_BAD_RD,
        OP_CTRL_WR,
        OP_MASK_WR,
        OP_PTR_WR,
        OP_SPRITE_WR,
        OP_SCROLL_WR,
        OP_ADDR_WR,
        OP_DATA_WR,
        OP_STATUS_LD
    } op_t;

    typedef struct packed {
        logic [1:0] kind;
        logic [2:0] reg_select;
        logic [7:0] write_data;
    } in_word_t;

    typedef struct packed {
        logic [7:0]  read_data;
        logic        bad_register;
        logic [14:0] vram_address;
        logic [14:0] temp_address;
        logic [2:0]  fine_x;
        logic [7:0]  control_byte;
        logic [7:0]  mask_byte;
    } out_word_t;

    typedef struct packed {
        op_t        op;
        logic [7:0] data;
    } cmd_t;

endpackage

[rtl/core/pur_ram.sv]
// generic single write port ram with registered read
`timescale 1ns / 1ps
module pur_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

[rtl/core/pur_front.sv]
// input side: decodes bus words into commands and queues them
`timescale 1ns / 1ps
module pur_front (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  pur_pkg::in_word_t s_data,
    output logic             q_valid,
    output pur_pkg::cmd_t    q_cmd,
    input  logic             q_pop
);
    import pur_pkg::*;

    cmd_t       slot_reg [2];
    logic       wptr_reg, wptr_next;
    logic       rptr_reg, rptr_next;
    logic [1:0] count_reg, count_next;
    cmd_t       dec;
    logic       push;

    always_comb begin
        dec.data = s_data.write_data;
        dec.op   = OP_NOP;
        unique case (s_data.kind)
            KIND_READ: begin
                unique case (s_data.reg_select)
                    REG_STATUS: dec.op = OP_STATUS_RD;
                    REG_SDATA:  dec.op = OP_SPRITE_RD;
                    REG_DATA:   dec.op = OP_DATA_RD;
                    default:    dec.op = OP_BAD_RD;
                endcase
            end
            KIND_WRITE: begin
                unique case (s_data.reg_select)
                    REG_CTRL:   dec.op = OP_CTRL_WR;
                    REG_MASK:   dec.op = OP_MASK_WR;
                    REG_STATUS: dec.op = OP_NOP;
                    REG_SPTR:   dec.op = OP_PTR_WR;
                    REG_SDATA:  dec.op = OP_SPRITE_WR;
                    REG_SCROLL: dec.op = OP_SCROLL_WR;
                    REG_ADDR:   dec.op = OP_ADDR_WR;
                    REG_DATA:   dec.op = OP_DATA_WR;
                    default:    dec.op = OP_NOP;
                endcase
            end
            KIND_STATUS: dec.op = OP_STATUS_LD;
            default:     dec.op = OP_NOP;
        endcase
    end

    assign s_ready = (count_reg != 2'd2);
    assign push    = s_valid && s_ready;
    assign q_valid = (count_reg != 2'd0);
    assign q_cmd   = slot_reg[rptr_reg];

    always_comb begin
        wptr_next  = push ? ~wptr_reg : wptr_reg;
        rptr_next  = q_pop ? ~rptr_reg : rptr_reg;
        count_next = count_reg + {1'b0, push} - {1'b0, q_pop};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg  <= 1'b0;
            rptr_reg  <= 1'b0;
            count_reg <= 2'd0;
        end else begin
            wptr_reg  <= wptr_next;
            rptr_reg  <= rptr_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wptr_reg] <= dec;
        end
    end
endmodule

[rtl/core/pur_back.sv]
// execution side: register file, memories and result register
`timescale 1ns / 1ps
module pur_back #(
    parameter int NAMETABLE_BYTES = 4096
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_wr_en,
    input  logic [1:0]        cfg_wr_data,
    input  logic              q_valid,
    input  pur_pkg::cmd_t     q_cmd,
    output logic              q_pop,
    output logic              m_valid,
    input  logic              m_ready,
    output pur_pkg::out_word_t m_data
);
    import pur_pkg::*;

    localparam int NT_AW  = $clog2(NAMETABLE_BYTES);
    localparam int PAT_AW = $clog2(PATTERN_BYTES);
    localparam int SPR_AW = $clog2(SPRITE_BYTES);
    localparam int PAL_AW = $clog2(PALETTE_ENTRIES);

    typedef enum logic {ST_IDLE, ST_FINISH} state_t;

    state_t      state_reg;
    logic [1:0]  mirror_reg;
    logic [14:0] video_reg, video_next;
    logic [14:0] temp_reg, temp_next;
    logic [2:0]  finex_reg, finex_next;
    logic        toggle_reg, toggle_next;
    logic [7:0]  ctrl_reg, ctrl_next;
    logic [7:0]  mask_reg, mask_next;
    logic [7:0]  status_reg, status_next;
    logic [SPR_AW-1:0] sptr_reg, sptr_next;
    logic [7:0]  rbuf_reg;
    logic        mval_reg;
    out_word_t   mdata_reg;

    op_t         op_reg;
    logic [7:0]  rd_pre_reg, rd_pre;
    logic        bad_reg, bad_pre;
    logic        pal_hit_reg, pat_hit_reg;
    logic [7:0]  pal_q_reg;
    logic [7:0]  palette [PALETTE_ENTRIES];

    logic        start;
    logic [13:0] va;
    logic        is_pat, is_pal;
    logic [1:0]  bank;
    logic [11:0] nt_full;
    logic [14:0] inc;
    logic [14:0] tmp;
    logic        pat_we, nt_we, spr_we, pal_we;
    logic [7:0]  pat_q, nt_q, spr_q, fetched, rd_final;

    assign start = (state_reg == ST_IDLE) && q_valid && (!mval_reg || m_ready);
    assign q_pop = start;

    assign va     = video_reg[13:0];
    assign is_pat = !va[13];
    assign is_pal = (va[13:8] == 6'h3F);
    assign inc    = ctrl_reg[2] ? 15'd32 : 15'd1;

    always_comb begin
        priority case (mirror_reg)
            MIRROR_HORZ: bank = {1'b0, va[11]};
            MIRROR_VERT: bank = {1'b0, va[10]};
            default:     bank = va[11:10];
        endcase
        nt_full = {bank, va[9:0]};
    end

    always_comb begin
        video_next  = video_reg;
        temp_next   = temp_reg;
        finex_next  = finex_reg;
        toggle_next = toggle_reg;
        ctrl_next   = ctrl_reg;
        mask_next   = mask_reg;
        status_next = status_reg;
        sptr_next   = sptr_reg;
        rd_pre      = 8'h00;
        bad_pre     = 1'b0;
        pat_we      = 1'b0;
        nt_we       = 1'b0;
        spr_we      = 1'b0;
        pal_we      = 1'b0;
        tmp         = temp_reg;
        if (start) begin
            unique case (q_cmd.op)
                OP_STATUS_RD: begin
                    rd_pre      = status_reg;
                    status_next = {1'b0, status_reg[6:0]};
                    toggle_next = 1'b0;
                end
                OP_DATA_RD: video_next = video_reg + inc;
                OP_BAD_RD: begin
                    rd_pre  = 8'hFF;
                    bad_pre = 1'b1;
                end
                OP_CTRL_WR: begin
                    ctrl_next = q_cmd.data;
                    temp_next = {temp_reg[14:12], q_cmd.data[1:0], temp_reg[9:0]};
                end
                OP_MASK_WR: mask_next = q_cmd.data;
                OP_PTR_WR:  sptr_next = q_cmd.data;
                OP_SPRITE_WR: begin
                    spr_we    = 1'b1;
                    sptr_next = sptr_reg + 1'b1;
                end
                OP_SCROLL_WR: begin
                    if (toggle_reg) begin
                        temp_next = {q_cmd.data[2:0], temp_reg[11:10], q_cmd.data[7:3],
                                     temp_reg[4:0]};
                        toggle_next = 1'b0;
                    end else begin
                        temp_next   = {temp_reg[14:5], q_cmd.data[7:3]};
                        finex_next  = q_cmd.data[2:0];
                        toggle_next = 1'b1;
                    end
                end
                OP_ADDR_WR: begin
                    if (toggle_reg) begin
                        tmp         = {temp_reg[14:8], q_cmd.data};
                        temp_next   = tmp;
                        video_next  = tmp;
                        toggle_next = 1'b0;
                    end else begin
                        temp_next   = {1'b0, q_cmd.data[5:0], temp_reg[7:0]};
                        toggle_next = 1'b1;
                    end
                end
                OP_DATA_WR: begin
                    pat_we     = is_pat;
                    nt_we      = !is_pat && !is_pal;
                    pal_we     = is_pal;
                    video_next = video_reg + inc;
                end
                OP_STATUS_LD: status_next = q_cmd.data;
                default: ;
            endcase
        end
    end

    pur_ram #(.WIDTH(8), .DEPTH(PATTERN_BYTES)) u_pattern (
        .aclk  (aclk),
        .we    (pat_we),
        .waddr (va[PAT_AW-1:0]),
        .wdata (q_cmd.data),
        .raddr (va[PAT_AW-1:0]),
        .rdata (pat_q)
    );

    pur_ram #(.WIDTH(8), .DEPTH(NAMETABLE_BYTES)) u_nametable (
        .aclk  (aclk),
        .we    (nt_we),
        .waddr (nt_full[NT_AW-1:0]),
        .wdata (q_cmd.data),
        .raddr (nt_full[NT_AW-1:0]),
        .rdata (nt_q)
    );

    pur_ram #(.WIDTH(8), .DEPTH(SPRITE_BYTES)) u_sprite (
        .aclk  (aclk),
        .we    (spr_we),
        .waddr (sptr_reg),
        .wdata (q_cmd.data),
        .raddr (sptr_reg),
        .rdata (spr_q)
    );

    // palette entries with low two bits clear are written to both halves
    always_ff @(posedge aclk) begin
        if (pal_we) begin
            if (va[1:0] != 2'b00) begin
                palette[va[PAL_AW-1:0]] <= q_cmd.data;
            end else begin
                palette[{1'b0, va[PAL_AW-2:0]}] <= q_cmd.data;
                palette[{1'b1, va[PAL_AW-2:0]}] <= q_cmd.data;
            end
        end
        if (start) begin
            pal_q_reg   <= palette[va[PAL_AW-1:0]];
            op_reg      <= q_cmd.op;
            rd_pre_reg  <= rd_pre;
            bad_reg     <= bad_pre;
            pal_hit_reg <= is_pal;
            pat_hit_reg <= is_pat;
        end
    end

    assign fetched = pat_hit_reg ? pat_q : nt_q;

    always_comb begin
        priority if (op_reg == OP_SPRITE_RD) begin
            rd_final = spr_q;
        end else if (op_reg == OP_DATA_RD) begin
            rd_final = pal_hit_reg ? pal_q_reg : rbuf_reg;
        end else begin
            rd_final = rd_pre_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            mirror_reg <= 2'd0;
            video_reg  <= '0;
            temp_reg   <= '0;
            finex_reg  <= '0;
            toggle_reg <= 1'b0;
            ctrl_reg   <= '0;
            mask_reg   <= '0;
            status_reg <= '0;
            sptr_reg   <= '0;
            rbuf_reg   <= '0;
            mval_reg   <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                mirror_reg <= cfg_wr_data;
            end
            video_reg  <= video_next;
            temp_reg   <= temp_next;
            finex_reg  <= finex_next;
            toggle_reg <= toggle_next;
            ctrl_reg   <= ctrl_next;
            mask_reg   <= mask_next;
            status_reg <= status_next;
            sptr_reg   <= sptr_next;
            if (mval_reg && m_ready) begin
                mval_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (start) begin
                        state_reg <= ST_FINISH;
                    end
                end
                ST_FINISH: begin
                    state_reg <= ST_IDLE;
                    mval_reg  <= 1'b1;
                    if (op_reg == OP_DATA_RD) begin
                        rbuf_reg <= fetched;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == ST_FINISH) begin
            mdata_reg.read_data    <= rd_final;
            mdata_reg.bad_register <= bad_reg;
            mdata_reg.vram_address <= video_reg;
            mdata_reg.temp_address <= temp_reg;
            mdata_reg.fine_x       <= finex_reg;
            mdata_reg.control_byte <= ctrl_reg;
            mdata_reg.mask_byte    <= mask_reg;
        end
    end

    assign m_valid = mval_reg;
    assign m_data  = mdata_reg;
endmodule

[rtl/core/picture_unit_register_port_unit.sv]
// top level of the picture unit register port
`timescale 1ns / 1ps
// usage
// - s_ channel: one bus word per access (read, write or status load from the
//   renderer), valid/ready handshake
// - m_ channel: one result word per input word, in order, carrying the read
//   byte, the bad register flag and a snapshot of the scroll and control state
// - cfg_wr_en / cfg_wr_data: nametable mirroring mode; the user must write it
//   only while idle, the block itself does not enforce this
// - the execution unit handles one word at a time: it issues the synchronous
//   memory read as it takes a word from the queue and, in its finish state,
//   takes the data (and writes the read buffer)
// - a two word queue between decode and execution takes input while the
//   execution unit works or waits on a full result register
// - receiver stall: the result register holds, execution halts, then the
//   queue fills and s_ready drops
// - reset (aresetn low, synchronous) clears the state and control registers
//   and the queue; result data and memories stay undefined until written
module picture_unit_register_port_unit #(
    parameter int NAMETABLE_BYTES = 4096
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_wr_en,
    input  logic [1:0]         cfg_wr_data,
    input  logic               s_valid,
    output logic               s_ready,
    input  pur_pkg::in_word_t  s_data,
    output logic               m_valid,
    input  logic               m_ready,
    output pur_pkg::out_word_t m_data
);
    import pur_pkg::*;

    // decoded command path between the two halves
    logic q_valid;
    logic q_pop;
    cmd_t q_cmd;

    // decode and queue
    pur_front u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .q_valid (q_valid),
        .q_cmd   (q_cmd),
        .q_pop   (q_pop)
    );

    // execution, memories and result register
    pur_back #(.NAMETABLE_BYTES(NAMETABLE_BYTES)) u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .q_valid     (q_valid),
        .q_cmd       (q_cmd),
        .q_pop       (q_pop),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data)
    );
endmodule

[rtl/core/pur_checker.sv]
// port level checks for the picture unit register port
`timescale 1ns / 1ps
module pur_checker (
    input logic               aclk,
    input logic               aresetn,
    input logic               m_valid,
    input logic               m_ready,
    input pur_pkg::out_word_t m_data
);
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result word changed while stalled");

    a_bad_ff: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.bad_register |-> m_data.read_data == 8'hFF)
        else $error("bad register flag without 0xff");

    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");
endmodule

bind picture_unit_register_port_unit pur_checker u_pur_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);
